// File: rtl/bqve_pkg.sv
// Shared types, codes and defaults for the batched quad vertex emitter.
`default_nettype none

package bqve_pkg;

	localparam int MAX_QUADS_DEF  = 1024;
	localparam int TEX_SLOTS_DEF  = 32;
	localparam int COORD_BITS_DEF = 21;

	localparam int POS_W = 63;

	localparam logic CMD_DRAW = 1'b0;
	localparam logic CMD_END  = 1'b1;

	localparam logic KIND_VERTEX = 1'b0;
	localparam logic KIND_FLUSH  = 1'b1;

	// Q8.8 one, used for untextured quads
	localparam logic [15:0] TILING_UNIT = 16'd256;

	localparam logic [1:0] CORNER_LAST = 2'd3;

	typedef struct packed {
		logic              cmd;
		logic [POS_W-1:0]  axis_x;
		logic [POS_W-1:0]  axis_y;
		logic [POS_W-1:0]  origin;
		logic [31:0]       color;
		logic [31:0]       texture_id;
		logic [15:0]       tiling;
		logic signed [31:0] entity_id;
	} item_t;

	typedef struct packed {
		logic              kind;
		logic [POS_W-1:0]  position;
		logic [31:0]       vertex_color;
		logic [1:0]        corner;
		logic [4:0]        tex_slot;
		logic [15:0]       vertex_tiling;
		logic signed [31:0] vertex_entity;
		logic [12:0]       index_count;
		logic [5:0]        slots_used;
		logic              last;
	} result_t;

	// controller -> datapath
	typedef struct packed {
		logic       load;
		logic       decide;
		logic       vert;
		logic [1:0] corner;
	} bqve_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic end_cmd;
	} bqve_stat_t;

endpackage

`default_nettype wire

// File: rtl/bqve_slot_table.sv
// Texture slot table: handle registers with a parallel compare against bound slots.
`default_nettype none

module bqve_slot_table
	import bqve_pkg::*;
#(
	parameter int TEX_SLOTS = TEX_SLOTS_DEF
) (
	input  wire logic                           clk,
	input  wire logic [31:0]                    tex,
	input  wire logic [$clog2(TEX_SLOTS+1)-1:0] ns,
	input  wire logic                           wr_en,
	input  wire logic [$clog2(TEX_SLOTS)-1:0]   wr_addr,
	output logic                                hit,
	output logic [$clog2(TEX_SLOTS)-1:0]        hit_slot
);

	localparam int NSW = $clog2(TEX_SLOTS + 1);
	localparam int SIW = $clog2(TEX_SLOTS);

	// slot 0 is the built-in white slot and has no handle
	logic [31:0]            handles_q [1:TEX_SLOTS-1];
	logic [TEX_SLOTS-1:1]   match;

	for (genvar i = 1; i < TEX_SLOTS; i++) begin : g_cmp
		assign match[i] = (NSW'(i) < ns) && (handles_q[i] == tex);
	end

	assign hit = |match;

	// handles within a batch are unique, so at most one match bit is set
	always_comb begin
		hit_slot = '0;
		for (int i = 1; i < TEX_SLOTS; i++) begin
			if (match[i]) begin
				hit_slot = hit_slot | SIW'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			handles_q[wr_addr] <= tex;
		end
	end

endmodule

`default_nettype wire

// File: rtl/bqve_datapath.sv
// Datapath: item register, batch counters, slot lookup and result register.
`default_nettype none

module bqve_datapath
	import bqve_pkg::*;
#(
	parameter int MAX_QUADS  = MAX_QUADS_DEF,
	parameter int TEX_SLOTS  = TEX_SLOTS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire item_t      item,
	input  wire bqve_cmd_t  cmd,
	output bqve_stat_t      stat,
	output logic            strobe,
	output result_t         result
);

	localparam int QCW = $clog2(MAX_QUADS + 1);
	localparam int NSW = $clog2(TEX_SLOTS + 1);
	localparam int SIW = $clog2(TEX_SLOTS);
	localparam int CW  = COORD_BITS;

	localparam logic [QCW-1:0] QC_MAX = QCW'(MAX_QUADS);
	localparam logic [NSW-1:0] NS_MAX = NSW'(TEX_SLOTS);

	localparam logic signed [CW+2:0] SAT_HI = {4'b0000, {(CW-1){1'b1}}};
	localparam logic signed [CW+2:0] SAT_LO = {4'b1111, {(CW-1){1'b0}}};
	localparam logic signed [CW+2:0] RND    = (CW+3)'(1);

	item_t          item_q;
	logic [QCW-1:0] qc_q;
	logic [NSW-1:0] ns_q;
	logic [SIW-1:0] slot_q;
	logic [15:0]    til_q;
	logic           strobe_q;
	result_t        result_q;

	logic           textured, full, miss, roll, hit;
	logic [SIW-1:0] hit_slot, slot_nx;
	logic [NSW-1:0] ns_nx;
	logic [QCW-1:0] qc_nx;
	logic           wr_en;

	logic [QCW+15:0] qc_ext, ic_full;
	logic [NSW+6:0]  ns_ext;
	logic [SIW+5:0]  slot_ext;
	logic            sx_neg, sy_neg;
	logic [POS_W-1:0] pos;
	result_t         flush_rec, vert_rec;

	assign stat.end_cmd = (item_q.cmd == CMD_END);

	// ---- slot decision ----
	assign textured = (item_q.texture_id != '0);
	assign full     = (qc_q >= QC_MAX);
	assign miss     = textured && !hit;
	assign roll     = full || (miss && (ns_q >= NS_MAX));

	always_comb begin
		if (roll) begin
			// new batch: a textured quad takes slot 1
			qc_nx   = QCW'(1);
			slot_nx = textured ? SIW'(1) : '0;
			ns_nx   = textured ? NSW'(2) : NSW'(1);
		end else begin
			qc_nx = qc_q + 1'b1;
			if (miss) begin
				slot_nx = ns_q[SIW-1:0];
				ns_nx   = ns_q + 1'b1;
			end else if (textured) begin
				slot_nx = hit_slot;
				ns_nx   = ns_q;
			end else begin
				slot_nx = '0;
				ns_nx   = ns_q;
			end
		end
	end

	assign wr_en = cmd.decide && (item_q.cmd == CMD_DRAW) && textured && (roll || miss);

	bqve_slot_table #(
		.TEX_SLOTS (TEX_SLOTS)
	) u_slots (
		.clk      (clk),
		.tex      (item_q.texture_id),
		.ns       (ns_q),
		.wr_en    (wr_en),
		.wr_addr  (slot_nx),
		.hit      (hit),
		.hit_slot (hit_slot)
	);

	// ---- flush record ----
	assign qc_ext  = (QCW+16)'(qc_q);
	assign ic_full = (qc_ext << 1) + (qc_ext << 2);
	assign ns_ext  = (NSW+7)'(ns_q);

	always_comb begin
		flush_rec             = '0;
		flush_rec.kind        = KIND_FLUSH;
		flush_rec.index_count = ic_full[12:0];
		flush_rec.slots_used  = ns_ext[5:0];
		flush_rec.last        = (item_q.cmd == CMD_END);
	end

	// ---- vertex arithmetic ----
	// corner signs: 0 (-,-), 1 (+,-), 2 (+,+), 3 (-,+)
	assign sx_neg = (cmd.corner[0] == cmd.corner[1]);
	assign sy_neg = !cmd.corner[1];

	for (genvar c = 0; c < 3; c++) begin : g_comp
		logic signed [CW+2:0] oe, ae, be, s, q;

		assign oe = {{3{item_q.origin[c*CW+CW-1]}}, item_q.origin[c*CW +: CW]};
		assign ae = {{3{item_q.axis_x[c*CW+CW-1]}}, item_q.axis_x[c*CW +: CW]};
		assign be = {{3{item_q.axis_y[c*CW+CW-1]}}, item_q.axis_y[c*CW +: CW]};
		// halve with round half up, then clamp
		assign s  = (oe <<< 1) + (sx_neg ? -ae : ae) + (sy_neg ? -be : be) + RND;
		assign q  = s >>> 1;
		assign pos[c*CW +: CW] = (q > SAT_HI) ? SAT_HI[CW-1:0] :
		                         (q < SAT_LO) ? SAT_LO[CW-1:0] : q[CW-1:0];
	end

	if (3 * CW < POS_W) begin : g_pos_pad
		assign pos[POS_W-1:3*CW] = '0;
	end

	assign slot_ext = (SIW+6)'(slot_q);

	always_comb begin
		vert_rec               = '0;
		vert_rec.kind          = KIND_VERTEX;
		vert_rec.position      = pos;
		vert_rec.vertex_color  = item_q.color;
		vert_rec.corner        = cmd.corner;
		vert_rec.tex_slot      = slot_ext[4:0];
		vert_rec.vertex_tiling = til_q;
		vert_rec.vertex_entity = item_q.entity_id;
		vert_rec.last          = (cmd.corner == CORNER_LAST);
	end

	// ---- registers ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qc_q     <= '0;
			ns_q     <= NSW'(1);
			strobe_q <= 1'b0;
		end else begin
			if (cmd.decide) begin
				if (item_q.cmd == CMD_END) begin
					strobe_q <= (qc_q != '0);
					qc_q     <= '0;
					ns_q     <= NSW'(1);
				end else begin
					strobe_q <= roll;
					qc_q     <= qc_nx;
					ns_q     <= ns_nx;
				end
			end else begin
				strobe_q <= cmd.vert;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
		if (cmd.decide) begin
			result_q <= flush_rec;
			slot_q   <= slot_nx;
			til_q    <= textured ? item_q.tiling : TILING_UNIT;
		end
		if (cmd.vert) begin
			result_q <= vert_rec;
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

endmodule

`default_nettype wire

// File: rtl/bqve_ctrl.sv
// Controller: sequences the decision cycle and the per-corner vertex cycles of a transaction.
`default_nettype none

module bqve_ctrl
	import bqve_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire bqve_stat_t stat,
	output logic            busy,
	output bqve_cmd_t       cmd
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_DECIDE = 2'd1;
	localparam logic [1:0] S_VERT   = 2'd2;

	logic [1:0] state_q, state_nx;
	logic [1:0] corner_q, corner_nx;
	logic       accept, vert_last;

	assign vert_last = (state_q == S_VERT) && (corner_q == CORNER_LAST);
	// the last vertex cycle already takes the next transaction
	assign busy   = !((state_q == S_IDLE) || vert_last);
	assign accept = start && !busy;

	always_comb begin
		state_nx  = state_q;
		corner_nx = corner_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_nx = S_DECIDE;
				end
			end
			S_DECIDE: begin
				corner_nx = '0;
				state_nx  = stat.end_cmd ? S_IDLE : S_VERT;
			end
			S_VERT: begin
				corner_nx = corner_q + 1'b1;
				if (corner_q == CORNER_LAST) begin
					state_nx = accept ? S_DECIDE : S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			corner_q <= '0;
		end else begin
			state_q  <= state_nx;
			corner_q <= corner_nx;
		end
	end

	assign cmd.load   = accept;
	assign cmd.decide = (state_q == S_DECIDE);
	assign cmd.vert   = (state_q == S_VERT);
	assign cmd.corner = corner_q;

endmodule

`default_nettype wire

// File: rtl/batched_quad_vertex_emitter.sv
// Top level of the batched quad vertex emitter: controller plus datapath.
// After start is taken, DECIDE loads a flush record into the result register and the VERT
// state then loads corners 0 to 3 in turn. The next transaction can be taken in the last vertex cycle;
//   an end-scene transaction stops after the decision cycle, in which a flush record rides.
// Results are one-cycle strobes; the receiver cannot stall, so there is no back-pressure.
// Reset clears the batch counters (quad count 0, next slot 1); slot handles are not cleared.
`default_nettype none

module batched_quad_vertex_emitter
	import bqve_pkg::*;
#(
	parameter int MAX_QUADS  = MAX_QUADS_DEF,
	parameter int TEX_SLOTS  = TEX_SLOTS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  start,
	output logic       busy,
	input  wire item_t item,
	output logic       strobe,
	output result_t    result
);

	bqve_cmd_t  cmd;
	bqve_stat_t stat;

	// Controller: IDLE -> DECIDE -> VERT for corners 0 to 3. DECIDE resolves the texture slot
	// against the bound handles and loads a flush record when the batch is full,
	// the slots are exhausted, or an end-scene closes a non-empty batch.
	bqve_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	// Datapath: holds the transaction, the batch counters, the slot table and
	// the result register. Each vertex cycle computes one corner, rounded and
	// saturated per component.
	bqve_datapath #(
		.MAX_QUADS  (MAX_QUADS),
		.TEX_SLOTS  (TEX_SLOTS),
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.stat   (stat),
		.strobe (strobe),
		.result (result)
	);

	// a taken transaction always occupies the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy low right after a transaction was taken");

	// a mid-transaction flush is followed at once by corner 0
	a_flush_then_vertex: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.kind == KIND_FLUSH && !result.last |=>
		strobe && result.kind == KIND_VERTEX && result.corner == 2'd0)
		else $error("flush record not followed by corner 0");

	// corners of one quad come out in consecutive cycles
	a_corner_run: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.kind == KIND_VERTEX && result.corner != CORNER_LAST |=>
		strobe && result.kind == KIND_VERTEX &&
		result.corner == 2'($past(result.corner) + 2'd1))
		else $error("vertex corners not consecutive");

	// last marks exactly the final corner of a vertex run
	a_last_corner: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.kind == KIND_VERTEX |->
		result.last == (result.corner == CORNER_LAST))
		else $error("last flag out of step with corner");

endmodule

`default_nettype wire

// File: verif/tb_batched_quad_vertex_emitter.sv
// Self-checking testbench for the batched quad vertex emitter: directed, slot, batch and random tests.
module tb_batched_quad_vertex_emitter;
	timeunit 1ns;
	timeprecision 1ps;

	import bqve_pkg::*;

	// Block configuration as instantiated (defaults)
	localparam int CB         = COORD_BITS_DEF;
	localparam int QUAD_LIMIT = MAX_QUADS_DEF;
	localparam int SLOT_LIMIT = TEX_SLOTS_DEF;
	localparam int POOL_SIZE  = 64;
	// Watchdog bound on the whole run, set with a wide margin
	localparam int CYCLE_LIMIT = 300000;

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	item_t   item;
	logic    strobe;
	result_t result;

	batched_quad_vertex_emitter u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.strobe (strobe),
		.result (result)
	);

	// Batch model state: quads in the open batch, next free slot, handles bound to slots
	int          batch_quads;
	int          batch_next_slot;
	logic [31:0] bound_handles [SLOT_LIMIT];

	// Records predicted but not yet seen on the result port, oldest first
	result_t     pending_records [$];

	int          error_count;
	int          cycle_count;
	bit          idle_enabled;
	logic [31:0] texture_pool [POOL_SIZE];

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog: a hung handshake or missing record ends the run here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("batched_quad_vertex_emitter verification failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	// One position component of one corner: (2*o + sx*ax + sy*ay) / 2, halving
	// rounds to nearest with ties toward +inf, then saturates to CB signed bits.
	function automatic logic [CB-1:0] corner_component(logic [POS_W-1:0] o,
			logic [POS_W-1:0] ax, logic [POS_W-1:0] ay, int comp, int sx, int sy);
		longint ov, axv, ayv, s, q, hi, lo;
		ov  = $signed(o[comp*CB +: CB]);
		axv = $signed(ax[comp*CB +: CB]);
		ayv = $signed(ay[comp*CB +: CB]);
		s   = 2 * ov + sx * axv + sy * ayv;
		q   = (s + 1) >>> 1;
		hi  = (longint'(1) << (CB - 1)) - 1;
		lo  = -hi - 1;
		if (q > hi)
			q = hi;
		if (q < lo)
			q = lo;
		return CB'(q);
	endfunction

	// Flush record for the open batch; the batch restarts after it
	function automatic void push_flush(logic last_flag);
		result_t rec;
		rec             = '0;
		rec.kind        = KIND_FLUSH;
		rec.index_count = 13'(batch_quads * 6);
		rec.slots_used  = 6'(batch_next_slot);
		rec.last        = last_flag;
		pending_records.push_back(rec);
		batch_quads     = 0;
		batch_next_slot = 1;
	endfunction

	// Works out every record one accepted transaction causes and queues them
	function automatic void predict_records(item_t it);
		result_t          rec;
		int               slot;
		int               sx, sy;
		logic [15:0]      til;
		logic [POS_W-1:0] pos;
		if (it.cmd == CMD_END) begin
			// empty batch: nothing emitted, batch restarted anyway
			if (batch_quads != 0)
				push_flush(1'b1);
			batch_quads     = 0;
			batch_next_slot = 1;
			return;
		end
		if (batch_quads >= QUAD_LIMIT)
			push_flush(1'b0);
		slot = 0;
		if (it.texture_id != 0) begin
			for (int i = 1; i < batch_next_slot && i < SLOT_LIMIT; i++) begin
				if (bound_handles[i] == it.texture_id) begin
					slot = i;
					break;
				end
			end
			if (slot == 0) begin
				// unknown handle with no free slot: close the batch first
				if (batch_next_slot >= SLOT_LIMIT)
					push_flush(1'b0);
				slot                  = batch_next_slot;
				bound_handles[slot]   = it.texture_id;
				batch_next_slot       = batch_next_slot + 1;
			end
			til = it.tiling;
		end else begin
			til = TILING_UNIT;
		end
		for (int k = 0; k < 4; k++) begin
			sx = (k == 1 || k == 2) ? 1 : -1;
			sy = (k >= 2) ? 1 : -1;
			for (int c = 0; c < 3; c++)
				pos[c*CB +: CB] = corner_component(it.origin, it.axis_x, it.axis_y, c, sx, sy);
			rec               = '0;
			rec.kind          = KIND_VERTEX;
			rec.position      = pos;
			rec.vertex_color  = it.color;
			rec.corner        = 2'(k);
			rec.tex_slot      = 5'(slot);
			rec.vertex_tiling = til;
			rec.vertex_entity = it.entity_id;
			rec.last          = (2'(k) == CORNER_LAST);
			pending_records.push_back(rec);
		end
		batch_quads = batch_quads + 1;
	endfunction

	// ------------------------------------------------------------------
	// Checking: every strobe pops the oldest prediction
	// ------------------------------------------------------------------

	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, want, got);
			error_count++;
		end
	endtask

	result_t want_rec;

	// Sampled at the rising edge, so values are those of the cycle just ending
	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (pending_records.size() == 0) begin
				$display("%0t ns: unexpected record, expected none actual %p", $time, result);
				error_count++;
			end else begin
				want_rec = pending_records.pop_front();
				check_field("kind", 64'(want_rec.kind), 64'(result.kind));
				check_field("position", 64'(want_rec.position), 64'(result.position));
				check_field("vertex_color", 64'(want_rec.vertex_color), 64'(result.vertex_color));
				check_field("corner", 64'(want_rec.corner), 64'(result.corner));
				check_field("tex_slot", 64'(want_rec.tex_slot), 64'(result.tex_slot));
				check_field("vertex_tiling", 64'(want_rec.vertex_tiling),
					64'(result.vertex_tiling));
				check_field("vertex_entity", 64'(unsigned'(want_rec.vertex_entity)),
					64'(unsigned'(result.vertex_entity)));
				check_field("index_count", 64'(want_rec.index_count), 64'(result.index_count));
				check_field("slots_used", 64'(want_rec.slots_used), 64'(result.slots_used));
				check_field("last", 64'(want_rec.last), 64'(result.last));
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Packed coordinate triple, each component at an extreme, small or anywhere
	function automatic logic [POS_W-1:0] random_coord();
		logic [POS_W-1:0] v;
		for (int c = 0; c < 3; c++) begin
			case ($urandom_range(0, 5))
				0:       v[c*CB +: CB] = {1'b0, {(CB-1){1'b1}}};
				1:       v[c*CB +: CB] = {1'b1, {(CB-1){1'b0}}};
				2, 3:    v[c*CB +: CB] = CB'($urandom());
				default: v[c*CB +: CB] = CB'(int'($urandom_range(0, 127)) - 64);
			endcase
		end
		return v;
	endfunction

	function automatic item_t random_draw(logic [31:0] tex);
		item_t it;
		it.cmd        = CMD_DRAW;
		it.axis_x     = random_coord();
		it.axis_y     = random_coord();
		it.origin     = random_coord();
		it.color      = $urandom();
		it.texture_id = tex;
		it.tiling     = 16'($urandom());
		it.entity_id  = $urandom();
		return it;
	endfunction

	// Drives one transaction from a falling edge and returns at the falling edge
	// after it is taken. start stays high on return so back-to-back transactions
	// never see start lowered and raised in the same step.
	task automatic send_item(item_t it);
		if (idle_enabled && $urandom_range(0, 9) < 3) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		start <= 1'b1;
		item  <= it;
		do
			@(posedge clk);
		while (busy);
		predict_records(it);
		@(negedge clk);
	endtask

	task automatic send_end_scene();
		item_t it;
		it     = random_draw(32'($urandom()));
		it.cmd = CMD_END;
		send_item(it);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Field extremes, saturation both ways, rounding ties, slot reuse,
	// untextured tiling override, empty and non-empty end scene.
	task automatic test_directed_extremes();
		item_t it;
		idle_enabled = 1'b0;
		// end scene straight after reset: batch empty, nothing emitted
		send_end_scene();
		// every component at max positive: far corner saturates high
		it        = random_draw(32'd0);
		it.origin = {3{1'b0, {(CB-1){1'b1}}}};
		it.axis_x = {3{1'b0, {(CB-1){1'b1}}}};
		it.axis_y = {3{1'b0, {(CB-1){1'b1}}}};
		send_item(it);
		// every component at min negative: saturates low
		it.origin = {3{1'b1, {(CB-1){1'b0}}}};
		it.axis_x = {3{1'b1, {(CB-1){1'b0}}}};
		it.axis_y = {3{1'b1, {(CB-1){1'b0}}}};
		send_item(it);
		// all zero, untextured with tiling 0 -> forced to unit
		send_item('0);
		// all ones: coords -1, max handle, max tiling, most negative entity
		it           = '1;
		it.cmd       = CMD_DRAW;
		it.entity_id = 32'sh8000_0000;
		send_item(it);
		// same handle again: slot reused, no new slot
		it           = random_draw(32'hFFFF_FFFF);
		it.entity_id = 32'sh7FFF_FFFF;
		send_item(it);
		// high bit handle with zero tiling
		it        = random_draw(32'h8000_0000);
		it.tiling = 16'h0000;
		send_item(it);
		// ties in the halving: odd sums of both signs
		it        = random_draw(32'd0);
		it.origin = '0;
		it.axis_x = {CB'(1), CB'(3), CB'(-1)};
		it.axis_y = {CB'(0), CB'(-2), CB'(1)};
		send_item(it);
		it.origin = {CB'(-1), CB'(1), CB'(-3)};
		send_item(it);
		// non-empty batch: one flush with last set
		send_end_scene();
		send_end_scene();
		send_item(random_draw(32'h0000_0001));
		send_item(random_draw(32'd0));
		send_end_scene();
	endtask

	// Fill slots 1..TEX_SLOTS-1, reuse one, then a new handle forces a flush
	task automatic test_slot_exhaustion();
		idle_enabled = 1'b1;
		for (int i = 1; i < SLOT_LIMIT; i++) begin
			if (i % 8 == 0)
				send_item(random_draw(32'd0));
			send_item(random_draw(32'h1000_0000 + i));
		end
		send_item(random_draw(32'h1000_0005));
		send_item(random_draw(32'hFFFF_0000));
		send_item(random_draw(32'h1000_0005));
		send_end_scene();
	endtask

	// MAX_QUADS quads in one batch; the next draw flushes 6*MAX_QUADS indices first
	task automatic test_full_batch();
		logic [31:0] tex;
		idle_enabled = 1'b0;
		for (int i = 0; i <= QUAD_LIMIT; i++) begin
			tex = (i % 3 == 0) ? 32'd0 : 32'hC0DE_0000 + 32'(i % 3);
			send_item(random_draw(tex));
		end
		send_end_scene();
	endtask

	// Batches of random length over handle sets of random width: wide sets run
	// out of slots, short batches and repeated end scenes hit the empty cases.
	task automatic test_random_traffic(int item_target);
		int sent;
		int seg_len;
		int pool_width;
		sent = 0;
		for (int i = 0; i < POOL_SIZE; i++) begin
			do
				texture_pool[i] = $urandom();
			while (texture_pool[i] == 0);
		end
		while (sent < item_target) begin
			seg_len    = $urandom_range(0, 60);
			pool_width = $urandom_range(1, POOL_SIZE);
			// final stretch runs with no sender gaps
			idle_enabled = (sent < item_target - 80) && ($urandom_range(0, 9) < 7);
			for (int j = 0; j < seg_len && sent < item_target; j++) begin
				if ($urandom_range(0, 4) == 0)
					send_item(random_draw(32'd0));
				else
					send_item(random_draw(texture_pool[$urandom_range(0, pool_width - 1)]));
				sent++;
			end
			send_end_scene();
			sent++;
			if ($urandom_range(0, 9) == 0) begin
				send_end_scene();
				sent++;
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		arst_n          = 1'b0;
		start           = 1'b0;
		item            = '0;
		idle_enabled    = 1'b0;
		batch_quads     = 0;
		batch_next_slot = 1;
		for (int i = 0; i < SLOT_LIMIT; i++)
			bound_handles[i] = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed_extremes();
		test_slot_exhaustion();
		test_full_batch();
		test_random_traffic(470);

		// drain: let every predicted record arrive, then watch for strays
		start <= 1'b0;
		while (pending_records.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);

		if (error_count == 0 && pending_records.size() == 0)
			$display("batched_quad_vertex_emitter verification clean");
		else
			$display("batched_quad_vertex_emitter verification failed");
		$finish;
	end

endmodule
